[rtl/core/tksel_pkg.sv]
// Package for the top-k strongest select core: command codes, payload
// structs and the list entry type shared by the cell row and the top level.
// No dependencies.
`timescale 1ns / 1ps

package tksel_pkg;

    // Command codes carried in the cmd field
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // One list entry
    typedef struct packed {
        logic        [7:0] record_index;
        logic signed [7:0] strength;
    } t_entry;

    // Input beat
    typedef struct packed {
        logic        [1:0] cmd;
        logic signed [7:0] strength;
        logic        [7:0] record_index;
        logic        [2:0] read_position;
    } t_in;

    // Output beat
    typedef struct packed {
        logic        [3:0] entry_count;
        logic              accepted;
        logic        [2:0] placed_position;
        logic        [7:0] read_record;
        logic signed [7:0] read_strength;
        logic              read_valid;
    } t_out;

    // Broadcast control for every cell of the row
    typedef struct packed {
        logic   clear;
        logic   insert;
        t_entry offer;
    } t_cell_ctl;

endpackage

[rtl/core/tksel_cell.sv]
// One compare-and-shift cell of the sorted list row.
// Depends on tksel_pkg (t_entry, t_cell_ctl).
`timescale 1ns / 1ps

module tksel_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tksel_pkg::t_cell_ctl   i_ctl,
    input  tksel_pkg::t_entry      i_prev_entry,
    input  logic                   i_prev_keep,
    input  logic                   i_prev_valid,
    output tksel_pkg::t_entry      o_entry,
    output logic                   o_keep,
    output logic                   o_valid
);

    tksel_pkg::t_entry r_entry, n_entry;
    logic              r_valid, n_valid;
    logic              w_keep;

    // Stay put when holding an entry at least as strong as the offer
    assign w_keep = r_valid && (r_entry.strength >= i_ctl.offer.strength);

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.insert && !w_keep) begin
            // Take the offer at the insertion point, else shift down from above
            n_entry = i_prev_keep ? i_ctl.offer : i_prev_entry;
            n_valid = r_valid | i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_keep  = w_keep;
    assign o_valid = r_valid;

endmodule

[rtl/core/top_k_strongest_select_core.sv]
// Top-k strongest select core: sorted list of the strongest records.
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the output is not stalled; every cell
// of the row compares and shifts in the same cycle.
// Reset (synchronous, active low) empties the list and drops the output beat.
// Depends on tksel_pkg and tksel_cell.
`timescale 1ns / 1ps

module top_k_strongest_select_core #(
    parameter int LIST_DEPTH = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // input channel
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  tksel_pkg::t_in  i_in_data,
    // output channel
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output tksel_pkg::t_out o_out_data
);

    // Width of the held count and of a list position
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int PW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    // Positions reachable by the 3-bit read position field
    localparam int RD = (LIST_DEPTH < 8) ? LIST_DEPTH : 8;

    logic                w_fire;
    tksel_pkg::t_cell_ctl w_ctl;

    // Row signals, indexed by cell
    tksel_pkg::t_entry   w_entry      [LIST_DEPTH];
    tksel_pkg::t_entry   w_prev_entry [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] w_keep;
    logic [LIST_DEPTH-1:0] w_valid;
    logic [LIST_DEPTH-1:0] w_prev_keep;
    logic [LIST_DEPTH-1:0] w_prev_valid;

    logic [CW-1:0]       r_count, n_count;
    logic                w_accepted;
    logic [PW-1:0]       w_place;
    tksel_pkg::t_entry   w_read_entry;
    logic                w_read_hit;

    logic                r_out_valid;
    tksel_pkg::t_out     r_out, n_out;

    // Accept whenever the output register is free or being drained
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_fire     = i_in_valid && !o_in_stall;

    assign w_ctl.clear        = w_fire && (i_in_data.cmd == tksel_pkg::CMD_CLEAR);
    assign w_ctl.insert       = w_fire && (i_in_data.cmd == tksel_pkg::CMD_INSERT);
    assign w_ctl.offer.record_index = i_in_data.record_index;
    assign w_ctl.offer.strength     = i_in_data.strength;

    // Wire each cell to its upper neighbor; the head cell sees the offer
    // as a neighbor that always keeps, so it takes the offer when it moves.
    always_comb begin
        w_prev_keep[0]  = 1'b1;
        w_prev_valid[0] = 1'b1;
        w_prev_entry[0] = w_ctl.offer;
        for (int i = 1; i < LIST_DEPTH; i++) begin
            w_prev_keep[i]  = w_keep[i-1];
            w_prev_valid[i] = w_valid[i-1];
            w_prev_entry[i] = w_entry[i-1];
        end
    end

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        tksel_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_prev_entry (w_prev_entry[g]),
            .i_prev_keep  (w_prev_keep[g]),
            .i_prev_valid (w_prev_valid[g]),
            .o_entry      (w_entry[g]),
            .o_keep       (w_keep[g]),
            .o_valid      (w_valid[g])
        );
    end

    // Keep flags form a prefix; the insertion point is the first cell that
    // moves. A full list where every cell keeps rejects the offer.
    assign w_accepted = !w_keep[LIST_DEPTH-1];

    always_comb begin
        w_place = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (!w_keep[i] && w_prev_keep[i]) begin
                w_place = w_place | PW'(i);
            end
        end
    end

    // Read select over the positions the read field can name
    assign w_read_hit = int'(i_in_data.read_position) < int'(r_count);

    always_comb begin
        w_read_entry = '0;
        for (int i = 0; i < RD; i++) begin
            if (i_in_data.read_position == 3'(i)) begin
                w_read_entry = w_read_entry | w_entry[i];
            end
        end
    end

    // Next count and result beat
    always_comb begin
        n_count = r_count;
        n_out   = '0;
        unique case (i_in_data.cmd)
            tksel_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            tksel_pkg::CMD_INSERT: begin
                if (w_accepted) begin
                    if (r_count != CW'(LIST_DEPTH)) begin
                        n_count = r_count + CW'(1);
                    end
                    n_out.accepted        = 1'b1;
                    n_out.placed_position = 3'(w_place);
                end
            end
            tksel_pkg::CMD_READ: begin
                if (w_read_hit) begin
                    n_out.read_valid    = 1'b1;
                    n_out.read_record   = w_read_entry.record_index;
                    n_out.read_strength = w_read_entry.strength;
                end
            end
            default: begin
                // unused code: report the count, change nothing
            end
        endcase
        n_out.entry_count = 4'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/core/tksel_checker.sv]
// Port-level checker for the top-k strongest select core, bound to the top.
// Depends on tksel_pkg and top_k_strongest_select_core.
`timescale 1ns / 1ps

module tksel_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input tksel_pkg::t_in  i_in_data,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input tksel_pkg::t_out o_out_data
);

    // Input side backs up only behind a held, stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stall without a blocked result beat");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result beat changed");

    // A rejected or non-insert beat reports no placement
    a_place_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.accepted) |-> (o_out_data.placed_position == 3'd0))
        else $error("placement reported without acceptance");

    // An accepted record leaves a non-empty list and no read data
    a_accept_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.accepted) |->
            (o_out_data.entry_count != 4'd0 && !o_out_data.read_valid))
        else $error("accepted insert with empty list or read data");

    // An accepted beat is answered on the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted beat produced no result");

endmodule

bind top_k_strongest_select_core tksel_checker u_tksel_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
